// ===== hdl/dpm_pkg.sv =====
// Shared types, constants and controller/datapath interfaces for the demand-paging MMU.
package dpm_pkg;

    localparam int NUM_PAGES  = 128;
    localparam int NUM_FRAMES = 16;
    localparam int PAGE_BYTES = 32;

    localparam int ADDR_W     = 16;
    localparam int OFF_W      = $clog2(PAGE_BYTES);
    localparam int PFIELD_W   = ADDR_W - OFF_W;
    localparam int CFG_W      = 8;
    localparam int STAMP_W    = 32;
    localparam int PHYS_W     = 9;
    localparam int PAGE_OUT_W = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic OP_STORE = 1'b1;

    localparam logic REG_SEL_READONLY = 1'b0;
    localparam logic REG_SEL_IMAGE    = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_ILLEGAL  = 3'd2,
        ST_RO_WRITE = 3'd3,
        ST_UNINIT   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_SWAP  = 2'd1,
        SRC_IMAGE = 2'd2,
        SRC_FRESH = 2'd3
    } t_fill_src;

    typedef struct packed {
        logic                  evict_writeback;
        logic [PAGE_OUT_W-1:0] evict_page;
        logic                  evicted;
        logic [PAGE_OUT_W-1:0] fill_page;
        t_fill_src             fill_source;
        logic [PHYS_W-1:0]     phys_addr;
        t_status               status;
    } t_result;

    typedef struct packed {
        logic clear;
        logic accept;
        logic check;
        logic eval;
        logic scan;
        logic vic_addr;
        logic vic_ev;
        logic fill;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic err;
        logic resident;
        logic uninit;
        logic have_free;
        logic scan_done;
    } t_dp_stat;

endpackage

// ===== hdl/dpm_datapath.sv =====
// Datapath: page table memory, frame stamp/owner memories, LRU scan, result registers.
module dpm_datapath #(
    parameter int NUM_PAGES  = dpm_pkg::NUM_PAGES,
    parameter int NUM_FRAMES = dpm_pkg::NUM_FRAMES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dpm_pkg::t_dp_cmd            i_cmd,
    output dpm_pkg::t_dp_stat           o_stat,
    input  logic                        i_op,
    input  logic [dpm_pkg::ADDR_W-1:0]  i_address,
    input  logic [dpm_pkg::CFG_W-1:0]   i_readonly_pages,
    input  logic [dpm_pkg::CFG_W-1:0]   i_image_pages,
    output dpm_pkg::t_result            o_result
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int FCW = $clog2(NUM_FRAMES + 1);

    typedef struct packed {
        logic          res;
        logic          swap;
        logic [FW-1:0] frame;
    } t_pte;

    t_pte                                r_page_mem [NUM_PAGES];
    logic [dpm_pkg::STAMP_W-1:0]         r_stamp_mem [NUM_FRAMES];
    logic [PW-1:0]                       r_owner_mem [NUM_FRAMES];

    logic                                r_op;
    logic [dpm_pkg::PFIELD_W-1:0]        r_page_full;
    logic [dpm_pkg::OFF_W-1:0]           r_off;
    logic [dpm_pkg::STAMP_W-1:0]         r_count;
    logic [PW-1:0]                       r_clr_idx;
    t_pte                                r_pg_q;
    logic                                r_own_swap;
    logic [FW-1:0]                       r_frame;
    logic                                r_from_free;
    logic [FCW-1:0]                      r_fill_cnt;
    logic [FW-1:0]                       r_scan_idx;
    logic                                r_scan_end;
    logic                                r_cmp_valid;
    logic [FW-1:0]                       r_cmp_idx;
    logic [FW-1:0]                       r_best;
    logic [dpm_pkg::STAMP_W-1:0]         r_best_stamp;
    logic [dpm_pkg::STAMP_W-1:0]         r_stamp_q;
    logic [PW-1:0]                       r_owner_q;
    dpm_pkg::t_result                    r_res;
    dpm_pkg::t_result                    r_out;

    logic [PW-1:0]                       page_idx;
    logic                                illegal;
    logic                                ro_err;
    logic                                in_image;
    logic                                is_store;
    logic                                uninit;
    logic                                have_free;
    logic                                take_best;
    logic                                scan_done;
    logic [PW-1:0]                       pg_raddr;
    logic                                pg_we;
    logic [PW-1:0]                       pg_waddr;
    t_pte                                pg_wdata;
    logic                                st_we;
    logic [FW-1:0]                       st_waddr;
    dpm_pkg::t_fill_src                  src;
    dpm_pkg::t_result                    err_res;

    assign page_idx  = PW'(r_page_full);
    assign is_store  = (r_op == dpm_pkg::OP_STORE);
    assign illegal   = 32'(r_page_full) >= 32'(NUM_PAGES);
    assign ro_err    = is_store && (r_page_full < dpm_pkg::PFIELD_W'(i_readonly_pages));
    assign in_image  = r_page_full < dpm_pkg::PFIELD_W'(i_image_pages);
    assign uninit    = !r_pg_q.res && !r_pg_q.swap && !in_image && !is_store;
    assign have_free = r_fill_cnt < FCW'(NUM_FRAMES);
    assign take_best = r_cmp_valid && ((r_cmp_idx == '0) || (r_stamp_q < r_best_stamp));
    assign scan_done = r_cmp_valid && (r_cmp_idx == FW'(NUM_FRAMES - 1));
    assign pg_raddr  = i_cmd.vic_addr ? r_owner_q : page_idx;

    always_comb begin
        if (r_pg_q.swap) begin
            src = dpm_pkg::SRC_SWAP;
        end else if (in_image) begin
            src = dpm_pkg::SRC_IMAGE;
        end else begin
            src = dpm_pkg::SRC_FRESH;
        end
    end

    always_comb begin
        err_res        = '0;
        err_res.status = illegal ? dpm_pkg::ST_ILLEGAL : dpm_pkg::ST_RO_WRITE;
    end

    assign o_stat.clr_last  = (r_clr_idx == PW'(NUM_PAGES - 1));
    assign o_stat.err       = illegal || ro_err;
    assign o_stat.resident  = r_pg_q.res;
    assign o_stat.uninit    = uninit;
    assign o_stat.have_free = have_free;
    assign o_stat.scan_done = scan_done;
    assign o_result         = r_out;

    // page table write port
    always_comb begin
        pg_we    = 1'b0;
        pg_waddr = page_idx;
        pg_wdata = '0;
        if (i_cmd.clear) begin
            pg_we    = 1'b1;
            pg_waddr = r_clr_idx;
        end else if (i_cmd.eval && r_pg_q.res && is_store) begin
            pg_we    = 1'b1;
            pg_wdata = '{res: 1'b1, swap: 1'b1, frame: r_pg_q.frame};
        end else if (i_cmd.vic_ev && r_pg_q.res) begin
            pg_we    = 1'b1;
            pg_waddr = r_owner_q;
            pg_wdata = '{res: 1'b0, swap: r_pg_q.swap, frame: '0};
        end else if (i_cmd.fill) begin
            pg_we    = 1'b1;
            pg_wdata = '{res: 1'b1, swap: r_own_swap | is_store, frame: r_frame};
        end
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_frame;
        if (i_cmd.eval && r_pg_q.res) begin
            st_we    = 1'b1;
            st_waddr = r_pg_q.frame;
        end else if (i_cmd.fill) begin
            st_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pg_q <= r_page_mem[pg_raddr];
        if (pg_we) begin
            r_page_mem[pg_waddr] <= pg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp_q <= r_stamp_mem[r_scan_idx];
        if (st_we) begin
            r_stamp_mem[st_waddr] <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_owner_q <= r_owner_mem[r_best];
        if (i_cmd.fill) begin
            r_owner_mem[r_frame] <= page_idx;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_fill_cnt  <= '0;
            r_cmp_valid <= 1'b0;
            r_scan_end  <= 1'b0;
            r_scan_idx  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.fill && r_from_free) begin
                r_fill_cnt <= r_fill_cnt + 1'b1;
            end
            if (i_cmd.eval) begin
                r_scan_idx  <= '0;
                r_scan_end  <= 1'b0;
                r_cmp_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                if (!r_scan_end) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                r_scan_end  <= r_scan_end | (r_scan_idx == FW'(NUM_FRAMES - 1));
                r_cmp_valid <= !r_scan_end;
            end else begin
                r_cmp_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= i_op;
            r_page_full <= i_address[dpm_pkg::ADDR_W-1:dpm_pkg::OFF_W];
            r_off       <= i_address[dpm_pkg::OFF_W-1:0];
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_scan_idx;
        end
        if (take_best) begin
            r_best       <= r_cmp_idx;
            r_best_stamp <= r_stamp_q;
        end
        if (i_cmd.check) begin
            r_res <= err_res;
        end
        if (i_cmd.eval) begin
            r_own_swap  <= r_pg_q.swap;
            r_from_free <= have_free;
            r_frame     <= FW'(r_fill_cnt);
            if (r_pg_q.res) begin
                r_res.status    <= dpm_pkg::ST_HIT;
                r_res.phys_addr <= dpm_pkg::PHYS_W'({r_pg_q.frame, r_off});
            end else if (uninit) begin
                r_res.status <= dpm_pkg::ST_UNINIT;
            end else begin
                r_res.fill_source <= src;
            end
        end
        if (i_cmd.vic_ev) begin
            r_frame <= r_best;
            if (r_pg_q.res) begin
                r_res.evicted         <= 1'b1;
                r_res.evict_page      <= dpm_pkg::PAGE_OUT_W'(r_owner_q);
                r_res.evict_writeback <= r_pg_q.swap;
            end
        end
        if (i_cmd.fill) begin
            r_res.status    <= dpm_pkg::ST_MISS;
            r_res.phys_addr <= dpm_pkg::PHYS_W'({r_frame, r_off});
            r_res.fill_page <= dpm_pkg::PAGE_OUT_W'(page_idx);
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

endmodule

// ===== hdl/dpm_ctrl.sv =====
// Controller state machine: table clear, lookup, LRU scan, eviction, fill and output handoff.
module dpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output dpm_pkg::t_dp_cmd  o_cmd,
    input  dpm_pkg::t_dp_stat i_stat
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_CHECK  = 10'b00_0000_0100,
        S_EVAL   = 10'b00_0000_1000,
        S_SCAN   = 10'b00_0001_0000,
        S_OWNRD  = 10'b00_0010_0000,
        S_VICRD  = 10'b00_0100_0000,
        S_VICEV  = 10'b00_1000_0000,
        S_FILL   = 10'b01_0000_0000,
        S_RESULT = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.accept   = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.vic_addr = (r_state == S_VICRD);
        o_cmd.vic_ev   = (r_state == S_VICEV);
        o_cmd.fill     = (r_state == S_FILL);
        o_cmd.load_out = (r_state == S_RESULT) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.err ? S_RESULT : S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.resident || i_stat.uninit) begin
                    n_state = S_RESULT;
                end else if (i_stat.have_free) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_OWNRD;
                end
            end
            S_OWNRD: n_state = S_VICRD;
            S_VICRD: n_state = S_VICEV;
            S_VICEV: n_state = S_FILL;
            S_FILL:  n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/demand_paging_mmu_lru_core.sv =====
// Top level: config registers, stream ports, controller and datapath.
//
//  port group   dir   handshake            word
//  s stream     in    i_s_tvalid/o_s_tready  op, address
//  m stream     out   o_m_tvalid/i_m_tready  status .. evict_writeback
//  APB          in    psel/penable/pready    readonly_pages, image_pages
//
// Per word: an error goes check, result; a hit or uninitialized load adds eval;
// a miss into a free frame adds fill; a miss with eviction adds the serial stamp
// scan over the frame memory, owner and victim reads and eviction before the fill.
// After reset a pass clears the page table before the first word is taken.
// A waiting result sits in the output register while the next word is accepted;
// a stalled output holds the block only in its final step.
module demand_paging_mmu_lru_core #(
    parameter int NUM_PAGES  = dpm_pkg::NUM_PAGES,
    parameter int NUM_FRAMES = dpm_pkg::NUM_FRAMES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [0] op, [16:1] address
    input  logic [dpm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [2:0] status, [11:3] phys_addr, [13:12] fill_source, [20:14] fill_page,
    // [21] evicted, [28:22] evict_page, [29] evict_writeback
    output logic [dpm_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dpm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dpm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [dpm_pkg::CFG_W-1:0] r_readonly_pages;
    logic [dpm_pkg::CFG_W-1:0] r_image_pages;
    logic                      reg_sel;
    logic                      cfg_we;
    dpm_pkg::t_dp_cmd          cmd;
    dpm_pkg::t_dp_stat         stat;
    dpm_pkg::t_result          result;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_readonly_pages <= '0;
            r_image_pages    <= '0;
        end else if (cfg_we) begin
            case (reg_sel)
                dpm_pkg::REG_SEL_READONLY: r_readonly_pages <= pwdata[dpm_pkg::CFG_W-1:0];
                dpm_pkg::REG_SEL_IMAGE:    r_image_pages    <= pwdata[dpm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            dpm_pkg::REG_SEL_READONLY: prdata = dpm_pkg::APB_DATA_W'(r_readonly_pages);
            dpm_pkg::REG_SEL_IMAGE:    prdata = dpm_pkg::APB_DATA_W'(r_image_pages);
            default:                   prdata = '0;
        endcase
    end

    assign o_m_tdata = dpm_pkg::OUT_DATA_W'(result);

    dpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    dpm_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_s_tdata[0]),
        .i_address        (i_s_tdata[dpm_pkg::ADDR_W:1]),
        .i_readonly_pages (r_readonly_pages),
        .i_image_pages    (r_image_pages),
        .o_result         (result)
    );

endmodule

// ===== hdl/dpm_checker.sv =====
// Port-level assertions for the MMU core, bound to the top level.
module dpm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [dpm_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    a_one_word_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted on back-to-back cycles");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] == dpm_pkg::ST_HIT
                     || o_m_tdata[2:0] == dpm_pkg::ST_MISS
                     || o_m_tdata[2:0] == dpm_pkg::ST_ILLEGAL
                     || o_m_tdata[2:0] == dpm_pkg::ST_RO_WRITE
                     || o_m_tdata[2:0] == dpm_pkg::ST_UNINIT))
        else $error("status code out of range");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[2:0] == dpm_pkg::ST_ILLEGAL
                     || o_m_tdata[2:0] == dpm_pkg::ST_RO_WRITE
                     || o_m_tdata[2:0] == dpm_pkg::ST_UNINIT))
        |-> (o_m_tdata[29:3] == '0))
        else $error("error word carries nonzero fields");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] == dpm_pkg::ST_HIT) |-> (o_m_tdata[29:12] == '0))
        else $error("hit word carries fill or evict fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output word changed");

endmodule

bind demand_paging_mmu_lru_core dpm_checker u_dpm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== bench/demand_paging_mmu_lru_core_tb.sv =====
// Testbench for demand_paging_mmu_lru_core: access streams checked against a page-table/LRU predictor.
module demand_paging_mmu_lru_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_LOAD      = ~dpm_pkg::OP_STORE;
    localparam int   FRAME_W      = $clog2(dpm_pkg::NUM_FRAMES);
    localparam int   PAGE_IDX_W   = $clog2(dpm_pkg::NUM_PAGES);
    localparam int   DRAIN_CYCLES = dpm_pkg::NUM_FRAMES + 16;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [dpm_pkg::IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [dpm_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                           psel       = 1'b0;
    logic                           penable    = 1'b0;
    logic                           pwrite     = 1'b0;
    logic [dpm_pkg::APB_ADDR_W-1:0] paddr      = '0;
    logic [dpm_pkg::APB_DATA_W-1:0] pwdata     = '0;
    logic [dpm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // predictor state
    logic                           res_map    [dpm_pkg::NUM_PAGES];
    logic                           swap_map   [dpm_pkg::NUM_PAGES];
    logic [FRAME_W-1:0]             frame_of   [dpm_pkg::NUM_PAGES];
    logic                           frame_busy [dpm_pkg::NUM_FRAMES];
    logic [dpm_pkg::STAMP_W-1:0]    frame_age  [dpm_pkg::NUM_FRAMES];
    logic [dpm_pkg::PAGE_OUT_W-1:0] frame_page [dpm_pkg::NUM_FRAMES];
    logic [dpm_pkg::STAMP_W-1:0]    attempt_ctr;
    logic [dpm_pkg::CFG_W-1:0]      ro_limit;
    logic [dpm_pkg::CFG_W-1:0]      img_limit;

    dpm_pkg::t_result expected_xlat[$];
    int      errors            = 0;
    bit      src_idle_en       = 1'b1;
    bit      sink_idle_en      = 1'b1;
    int      sink_hold_cycles  = 0;
    int      ws_base           = 0;
    int      ws_span           = 24;

    demand_paging_mmu_lru_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic clear_model;
        int i;
        for (i = 0; i < dpm_pkg::NUM_PAGES; i++) begin
            res_map[i]  = 1'b0;
            swap_map[i] = 1'b0;
            frame_of[i] = '0;
        end
        for (i = 0; i < dpm_pkg::NUM_FRAMES; i++) begin
            frame_busy[i] = 1'b0;
            frame_age[i]  = '0;
            frame_page[i] = '0;
        end
        attempt_ctr = '0;
        ro_limit    = '0;
        img_limit   = '0;
    endtask

    function automatic dpm_pkg::t_result translate_access(input logic op,
                                                          input logic [dpm_pkg::ADDR_W-1:0] addr);
        logic [dpm_pkg::PFIELD_W-1:0] page;
        logic [PAGE_IDX_W-1:0]        pidx;
        logic [dpm_pkg::OFF_W-1:0]    offset;
        logic [FRAME_W-1:0]           frame;
        dpm_pkg::t_fill_src           src;
        dpm_pkg::t_result             r;
        int                           best;
        int                           f;
        page        = addr[dpm_pkg::ADDR_W-1:dpm_pkg::OFF_W];
        pidx        = page[PAGE_IDX_W-1:0];
        offset      = addr[dpm_pkg::OFF_W-1:0];
        attempt_ctr = attempt_ctr + 1;
        r           = '0;
        if (page >= dpm_pkg::NUM_PAGES) begin
            r.status = dpm_pkg::ST_ILLEGAL;
            return r;
        end
        if (op == dpm_pkg::OP_STORE && page < ro_limit) begin
            r.status = dpm_pkg::ST_RO_WRITE;
            return r;
        end
        if (res_map[pidx]) begin
            frame            = frame_of[pidx];
            frame_age[frame] = attempt_ctr;
            if (op == dpm_pkg::OP_STORE) swap_map[pidx] = 1'b1;
            r.status = dpm_pkg::ST_HIT;
        end else begin
            if (swap_map[pidx]) begin
                src = dpm_pkg::SRC_SWAP;
            end else if (page < img_limit) begin
                src = dpm_pkg::SRC_IMAGE;
            end else if (op == dpm_pkg::OP_STORE) begin
                src = dpm_pkg::SRC_FRESH;
            end else begin
                r.status = dpm_pkg::ST_UNINIT;
                return r;
            end
            best = -1;
            for (f = 0; f < dpm_pkg::NUM_FRAMES; f++)
                if (!frame_busy[f] && best < 0) best = f;
            if (best < 0) begin
                // all frames taken: oldest stamp, lowest frame on a tie
                best = 0;
                for (f = 1; f < dpm_pkg::NUM_FRAMES; f++)
                    if (frame_age[f] < frame_age[best]) best = f;
                if (res_map[frame_page[best]]) begin
                    r.evicted               = 1'b1;
                    r.evict_page            = frame_page[best];
                    r.evict_writeback       = swap_map[frame_page[best]];
                    res_map[frame_page[best]] = 1'b0;
                end
            end
            frame             = best[FRAME_W-1:0];
            frame_age[frame]  = attempt_ctr;
            frame_page[frame] = page[dpm_pkg::PAGE_OUT_W-1:0];
            frame_busy[frame] = 1'b1;
            frame_of[pidx]    = frame;
            res_map[pidx]     = 1'b1;
            if (op == dpm_pkg::OP_STORE) swap_map[pidx] = 1'b1;
            r.status      = dpm_pkg::ST_MISS;
            r.fill_source = src;
            r.fill_page   = page[dpm_pkg::PAGE_OUT_W-1:0];
        end
        r.phys_addr = {frame, offset};
        return r;
    endfunction

    task automatic send_word(input logic op, input logic [dpm_pkg::ADDR_W-1:0] addr);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(dpm_pkg::IN_DATA_W-dpm_pkg::ADDR_W-1){1'b0}}, addr, op};
        do @(posedge i_clk); while (!o_s_tready);
        expected_xlat.push_back(translate_access(op, addr));
    endtask

    task automatic drain_block;
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_xlat.size() != 0);
    endtask

    task automatic write_reg(input logic sel, input logic [dpm_pkg::CFG_W-1:0] value);
        logic [dpm_pkg::APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= dpm_pkg::APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == dpm_pkg::REG_SEL_READONLY) ro_limit = value;
        else img_limit = value;
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== dpm_pkg::APB_DATA_W'(value)) begin
            $display("%0t: register %0d readback expected %0d actual %0d",
                     $time, sel, value, rd);
            errors++;
        end
    endtask

    task automatic next_access(output logic op, output logic [dpm_pkg::ADDR_W-1:0] addr);
        int pick;
        int page;
        pick = $urandom_range(0, 99);
        op   = 1'($urandom_range(0, 1));
        if (pick < 70) begin
            page = ws_base + $urandom_range(0, ws_span - 1);
            addr = dpm_pkg::ADDR_W'(page * dpm_pkg::PAGE_BYTES
                                    + $urandom_range(0, dpm_pkg::PAGE_BYTES - 1));
        end else if (pick < 85) begin
            page = $urandom_range(0, dpm_pkg::NUM_PAGES - 1);
            addr = dpm_pkg::ADDR_W'(page * dpm_pkg::PAGE_BYTES
                                    + $urandom_range(0, dpm_pkg::PAGE_BYTES - 1));
        end else if (pick < 95) begin
            addr = dpm_pkg::ADDR_W'($urandom_range(0, 65535));
        end else begin
            page = $urandom_range(dpm_pkg::NUM_PAGES, (1 << dpm_pkg::PFIELD_W) - 1);
            addr = dpm_pkg::ADDR_W'(page * dpm_pkg::PAGE_BYTES
                                    + $urandom_range(0, dpm_pkg::PAGE_BYTES - 1));
        end
    endtask

    task automatic send_random(input int count);
        logic                       op;
        logic [dpm_pkg::ADDR_W-1:0] addr;
        repeat (count) begin
            next_access(op, addr);
            send_word(op, addr);
        end
    endtask

    task automatic run_phase(input logic [dpm_pkg::CFG_W-1:0] ro,
                             input logic [dpm_pkg::CFG_W-1:0] img,
                             input int count);
        drain_block();
        write_reg(dpm_pkg::REG_SEL_READONLY, ro);
        write_reg(dpm_pkg::REG_SEL_IMAGE, img);
        ws_span = $urandom_range(18, 36);
        ws_base = $urandom_range(0, dpm_pkg::NUM_PAGES - ws_span);
        send_random(count);
    endtask

    task automatic test_directed;
        int p;
        write_reg(dpm_pkg::REG_SEL_READONLY, 8'd4);
        write_reg(dpm_pkg::REG_SEL_IMAGE, 8'd8);
        send_word(OP_LOAD, 16'h0000);   // image fill into first free frame
        send_word(OP_LOAD, 16'h001F);   // hit, top offset
        send_word(dpm_pkg::OP_STORE, 16'h0040);  // read-only page
        send_word(dpm_pkg::OP_STORE, 16'h0080);  // image fill, page now dirty
        send_word(dpm_pkg::OP_STORE, 16'h0C85);  // fresh page
        send_word(OP_LOAD, 16'h0CA0);   // never written
        send_word(OP_LOAD, 16'hFFFF);   // illegal
        send_word(dpm_pkg::OP_STORE, 16'h1000);  // first illegal page
        send_word(dpm_pkg::OP_STORE, 16'h0FFF);  // last legal page, fresh
        send_word(OP_LOAD, 16'h0FE0);   // hit on it
        for (p = 16; p < 28; p++)
            send_word(dpm_pkg::OP_STORE, dpm_pkg::ADDR_W'(p * dpm_pkg::PAGE_BYTES));
        // clean LRU victim
        send_word(dpm_pkg::OP_STORE, dpm_pkg::ADDR_W'(28 * dpm_pkg::PAGE_BYTES));
        // dirty victim
        send_word(dpm_pkg::OP_STORE, dpm_pkg::ADDR_W'(29 * dpm_pkg::PAGE_BYTES + 3));
        send_word(OP_LOAD, 16'h0085);   // refill from swap
        drain_block();
    endtask

    task automatic test_limit_sweep;
        run_phase(8'd0, 8'd0, 230);
        run_phase(8'd128, 8'd128, 230);
        run_phase(8'd0, 8'd128, 230);
        run_phase(8'd128, 8'd0, 230);
        run_phase(dpm_pkg::CFG_W'($urandom_range(0, 128)),
                  dpm_pkg::CFG_W'($urandom_range(0, 128)), 230);
        run_phase(dpm_pkg::CFG_W'($urandom_range(0, 40)),
                  dpm_pkg::CFG_W'($urandom_range(20, 128)), 230);
        drain_block();
    endtask

    task automatic test_output_stall;
        src_idle_en      = 1'b0;
        sink_hold_cycles = 300;
        send_random(60);
        src_idle_en = 1'b1;
        drain_block();
    endtask

    task automatic test_streaming;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_phase(dpm_pkg::CFG_W'($urandom_range(0, 16)),
                  dpm_pkg::CFG_W'($urandom_range(0, 64)), 200);
    endtask

    initial begin : sink_pacing
        int span;
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                span             = sink_hold_cycles;
                sink_hold_cycles = 0;
                i_m_tready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                span = $urandom_range(1, 10);
                i_m_tready <= 1'b0;
            end else begin
                span = $urandom_range(1, 24);
                i_m_tready <= 1'b1;
            end
            repeat (span) @(posedge i_clk);
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        dpm_pkg::t_result got;
        dpm_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = dpm_pkg::t_result'(o_m_tdata[$bits(dpm_pkg::t_result)-1:0]);
            if (expected_xlat.size() == 0) begin
                $display("%0t: word expected none actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = expected_xlat.pop_front();
                check_field("status", want.status, got.status);
                check_field("phys_addr", want.phys_addr, got.phys_addr);
                check_field("fill_source", want.fill_source, got.fill_source);
                check_field("fill_page", want.fill_page, got.fill_page);
                check_field("evicted", want.evicted, got.evicted);
                check_field("evict_page", want.evict_page, got.evict_page);
                check_field("evict_writeback", want.evict_writeback, got.evict_writeback);
            end
        end
    end

    initial begin
        clear_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_limit_sweep();
        test_output_stall();
        test_streaming();
        drain_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("demand_paging_mmu_lru_core_tb: clean");
        end else begin
            $display("demand_paging_mmu_lru_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("demand_paging_mmu_lru_core_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dpm_pkg.sv
hdl/dpm_datapath.sv
hdl/dpm_ctrl.sv
hdl/demand_paging_mmu_lru_core.sv
hdl/dpm_checker.sv
bench/demand_paging_mmu_lru_core_tb.sv
